// ===== rtl/core/sha256_pkg.sv =====
// Package: SHA-256 constants, command/status types and round functions.
package sha256_pkg;

    localparam int unsigned ROUNDS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } state_t;

    // command from controller to datapath
    typedef struct packed {
        logic       absorb;      // write data_byte at fill position, count bits
        logic       pad_write;   // write padding byte at fill position
        logic       load;        // working vars <- hash, schedule <- buffer
        logic       round;       // one compression round
        logic       update;      // hash += working vars
        logic       clear_msg;   // hash/count/fill back to initial
        logic       emit_next;   // advance output word
        logic       emit_start;  // output word index to zero
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       block_full;  // fill position at 63: this byte completes the block
        logic       round_last;  // round counter at 63
        logic       pad_done;    // last padding byte written
        logic       pad_block;   // padding needs a compression now
        logic       emit_last;   // word index at 7
    } status_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h [0:7];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha256_ctrl.sv =====
// Controller: sequences absorb, padding, compression and digest output.
module sha256_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic                req_type,
    output logic                out_valid,
    input  logic                out_ready,
    input  sha256_pkg::status_t sts,
    output sha256_pkg::cmd_t    cmd
);

    sha256_pkg::state_t state_reg, state_next;
    logic               fin_reg, fin_next;   // compression belongs to a finish

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        ready      = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    if (!req_type)
                    begin
                        cmd.absorb = 1'b1;
                        if (sts.block_full)
                        begin
                            fin_next   = 1'b0;
                            state_next = sha256_pkg::ST_LOAD;
                        end
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                cmd.pad_write = 1'b1;
                if (sts.pad_block || sts.pad_done)
                    state_next = sha256_pkg::ST_LOAD;
            end
            sha256_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_last)
                    state_next = sha256_pkg::ST_UPDATE;
            end
            sha256_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (!fin_reg)
                    state_next = sha256_pkg::ST_IDLE;
                else if (sts.pad_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = sha256_pkg::ST_EMIT;
                end
                else
                    state_next = sha256_pkg::ST_PAD;
            end
            sha256_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.clear_msg = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/sha256_dpath.sv =====
// Datapath: block buffer, bit count, message schedule, round logic, hash words.
module sha256_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha256_pkg::cmd_t    cmd,
    input  logic [7:0]          data_byte,
    output sha256_pkg::status_t sts,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);

    logic [31:0] blk_mem [0:15];   // block buffer, four bytes a word, big-endian
    logic [63:0] bits_reg;
    logic [5:0]  fill_reg;
    logic        done_reg;      // length bytes written, block is final
    logic        first_pad_reg; // next padding byte is the 0x80 marker
    logic        spill_reg;     // marker landed inside the length field
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  pad_byte;
    logic [31:0] w_cur, w_new, s0, s1, b0, b1, ch, maj, t1, t2;
    logic [2:0]  len_sel;

    // padding byte for current fill position: length bytes from 56 on unless spilling, else zeros
    always_comb
    begin
        len_sel = fill_reg[2:0];
        if (done_reg)
            pad_byte = 8'h00;
        else if (fill_reg >= 6'd56 && !spill_reg)
            pad_byte = bits_reg[8 * (7 - len_sel) +: 8];
        else
            pad_byte = 8'h00;
    end

    assign sts.block_full = (fill_reg == 6'd63);
    assign sts.round_last = (rnd_reg == 6'd63);
    assign sts.emit_last  = (idx_reg == 3'd7);
    // marker landed inside the length field: spill into a second block
    assign sts.pad_block  = !done_reg && (fill_reg == 6'd63) && spill_reg;
    assign sts.pad_done   = done_reg || (fill_reg == 6'd63 && !spill_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
            blk_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= data_byte;
        else if (cmd.pad_write)
            blk_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <=
                first_pad_reg ? 8'h80 : pad_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            first_pad_reg <= 1'b1;
            spill_reg     <= 1'b0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::init_h(3'(i));
        end
        else
        begin
            if (cmd.absorb)
            begin
                bits_reg <= bits_reg + 64'd8;
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.pad_write)
            begin
                first_pad_reg <= 1'b0;
                if (fill_reg == 6'd63)
                begin
                    if (!(spill_reg || first_pad_reg))
                        done_reg <= 1'b1;
                    spill_reg <= 1'b0;
                end
                else if (first_pad_reg)
                    spill_reg <= (fill_reg >= 6'd56);
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.load)
                rnd_reg <= '0;
            if (cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.update)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.emit_start)
                idx_reg <= '0;
            if (cmd.emit_next)
                idx_reg <= idx_reg + 3'd1;
            if (cmd.clear_msg)
            begin
                bits_reg      <= '0;
                fill_reg      <= '0;
                done_reg      <= 1'b0;
                first_pad_reg <= 1'b1;
                spill_reg     <= 1'b0;
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha256_pkg::init_h(3'(i));
            end
        end
    end

    // schedule: sliding window of 16 words; words loaded from buffer in load
    assign s0    = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
                 ^ (w_reg[1] >> 3);
    assign s1    = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
                 ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign w_cur = w_reg[0];

    assign b1  = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
               ^ sha256_pkg::rotr(v_reg[4], 25);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + b1 + ch + sha256_pkg::round_k(rnd_reg) + w_cur;
    assign b0  = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
               ^ sha256_pkg::rotr(v_reg[0], 22);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = b0 + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk_mem[i];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_core.sv =====
// Top level: SHA-256 byte-stream hasher, controller plus datapath.
//
// Input channel (valid/ready, req_type, data_byte): req_type 0 absorbs one
// message byte, req_type 1 finishes the message.
// Output channel (out_valid/out_ready): eight digest items, H0 first, with
// word_index 0..7 and last_word set on the eighth.
// An absorb stores one byte; the 64th byte of a block starts the compression
// (load, 64 rounds of the single round unit, hash update).
// A finish writes padding one byte a cycle into the block buffer up to the
// block end, compresses, and repeats once if the length field spills into a
// second block, before the first digest item is shown.
// One item is worked on at a time; ready is low until the block is idle.
// When the receiver stalls, the current digest item holds and the block
// waits; after the eighth item the hash state, bit count and fill position
// return to their initial values for the next message.
// Reset (rst_n, asynchronous) loads the initial hash values and clears the
// bit count; it leaves the block idle and ready.
module sha256_byte_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::cmd_t    cmd;
    sha256_pkg::status_t sts;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sha256_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .sts         (sts),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

// ===== rtl/core/sha256_checker.sv =====
// Checker: port-level properties of the hasher, bound to the top level.
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready && out_valid))
        else $error("input taken while digest pending");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=>
            (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest word order broken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(digest_word))
        else $error("digest changed under stall");

endmodule

bind sha256_byte_stream_hasher_core sha256_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .ready       (ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
